// ===== src/assert_macros.svh =====
// Assertion macros shared by the droop controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/pqfd_pkg.sv =====
// Package: widths, register indexes, operand selects and the step schedule.
`timescale 1ns / 1ps
`default_nettype none
package pqfd_pkg;

	localparam int SMP_W  = 16;
	localparam int PWR_W  = 32;
	localparam int OPND_W = 33;
	localparam int ACC_W  = 66;
	localparam int STEP_W = 4;
	localparam int NOMF_W = 31;
	localparam int CIDX_W = 8;

	localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_FREQ_GAIN = 8'd0;
	localparam logic [CIDX_W-1:0] REG_VOLT_GAIN = 8'd1;
	localparam logic [CIDX_W-1:0] REG_P_SET     = 8'd2;
	localparam logic [CIDX_W-1:0] REG_Q_SET     = 8'd3;
	localparam logic [CIDX_W-1:0] REG_NOM_FREQ  = 8'd4;
	localparam logic [CIDX_W-1:0] REG_COEF_CUR  = 8'd5;
	localparam logic [CIDX_W-1:0] REG_COEF_PREV = 8'd6;
	localparam logic [CIDX_W-1:0] REG_COEF_FB   = 8'd7;

	// Multiplier A operand selects
	localparam logic [2:0] A_VA = 3'd0;
	localparam logic [2:0] A_VB = 3'd1;
	localparam logic [2:0] A_CC = 3'd2;
	localparam logic [2:0] A_CP = 3'd3;
	localparam logic [2:0] A_CF = 3'd4;
	localparam logic [2:0] A_FG = 3'd5;
	localparam logic [2:0] A_VG = 3'd6;

	// Multiplier B operand selects
	localparam logic [3:0] B_IA  = 4'd0;
	localparam logic [3:0] B_IB  = 4'd1;
	localparam logic [3:0] B_P   = 4'd2;
	localparam logic [3:0] B_LRP = 4'd3;
	localparam logic [3:0] B_LFP = 4'd4;
	localparam logic [3:0] B_Q   = 4'd5;
	localparam logic [3:0] B_LRQ = 4'd6;
	localparam logic [3:0] B_LFQ = 4'd7;
	localparam logic [3:0] B_DP  = 4'd8;
	localparam logic [3:0] B_DQ  = 4'd9;

	// Accumulator start values
	localparam logic [1:0] BIAS_ZERO = 2'd0;
	localparam logic [1:0] BIAS_FILT = 2'd1;
	localparam logic [1:0] BIAS_FREQ = 2'd2;
	localparam logic [1:0] BIAS_VOLT = 2'd3;

	// Accumulator capture targets
	localparam logic [2:0] CAP_NONE = 3'd0;
	localparam logic [2:0] CAP_P    = 3'd1;
	localparam logic [2:0] CAP_Q    = 3'd2;
	localparam logic [2:0] CAP_PF   = 3'd3;
	localparam logic [2:0] CAP_QF   = 3'd4;
	localparam logic [2:0] CAP_WREF = 3'd5;

	typedef struct packed {
		logic vld;
		logic first;
		logic sub;
	} mac_ctl_t;

	typedef struct packed {
		mac_ctl_t   mac;
		logic [2:0] a_sel;
		logic [3:0] b_sel;
		logic [1:0] bias_sel;
		logic [2:0] cap_sel;
		logic       dif_p;
		logic       dif_q;
		logic       fin;
	} ctrl_t;

	// Schedule: at most one multiply per step; a sum is read after its last term clears both MAC registers
	function automatic ctrl_t step_ctrl(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		unique case (step)
			4'd0: begin
				c.mac = '{vld: 1'b1, first: 1'b1, sub: 1'b0};
				c.a_sel = A_VA; c.b_sel = B_IA; c.bias_sel = BIAS_ZERO;
			end
			4'd1: begin
				c.mac = '{vld: 1'b1, first: 1'b0, sub: 1'b0};
				c.a_sel = A_VB; c.b_sel = B_IB;
			end
			4'd2: begin
				c.mac = '{vld: 1'b1, first: 1'b1, sub: 1'b0};
				c.a_sel = A_VB; c.b_sel = B_IA; c.bias_sel = BIAS_ZERO;
			end
			4'd3: begin
				c.mac = '{vld: 1'b1, first: 1'b0, sub: 1'b1};
				c.a_sel = A_VA; c.b_sel = B_IB; c.cap_sel = CAP_P;
			end
			4'd4: begin
				c.mac = '{vld: 1'b1, first: 1'b1, sub: 1'b0};
				c.a_sel = A_CC; c.b_sel = B_P; c.bias_sel = BIAS_FILT;
			end
			4'd5: begin
				c.mac = '{vld: 1'b1, first: 1'b0, sub: 1'b0};
				c.a_sel = A_CP; c.b_sel = B_LRP; c.cap_sel = CAP_Q;
			end
			4'd6: begin
				c.mac = '{vld: 1'b1, first: 1'b0, sub: 1'b1};
				c.a_sel = A_CF; c.b_sel = B_LFP;
			end
			4'd7: begin
				c.mac = '{vld: 1'b1, first: 1'b1, sub: 1'b0};
				c.a_sel = A_CC; c.b_sel = B_Q; c.bias_sel = BIAS_FILT;
			end
			4'd8: begin
				c.mac = '{vld: 1'b1, first: 1'b0, sub: 1'b0};
				c.a_sel = A_CP; c.b_sel = B_LRQ; c.cap_sel = CAP_PF;
			end
			4'd9: begin
				c.mac = '{vld: 1'b1, first: 1'b0, sub: 1'b1};
				c.a_sel = A_CF; c.b_sel = B_LFQ; c.dif_p = 1'b1;
			end
			4'd10: begin
				c.mac = '{vld: 1'b1, first: 1'b1, sub: 1'b0};
				c.a_sel = A_FG; c.b_sel = B_DP; c.bias_sel = BIAS_FREQ;
			end
			4'd11: begin
				c.cap_sel = CAP_QF;
			end
			4'd12: begin
				c.cap_sel = CAP_WREF; c.dif_q = 1'b1;
			end
			4'd13: begin
				c.mac = '{vld: 1'b1, first: 1'b1, sub: 1'b0};
				c.a_sel = A_VG; c.b_sel = B_DQ; c.bias_sel = BIAS_VOLT;
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

	// Clamp a 52-bit signed value to 32 bits signed
	function automatic logic [PWR_W-1:0] sat32(input logic [51:0] x);
		logic [PWR_W-1:0] r;
		if ((x[51:31] == '0) || (x[51:31] == '1)) begin
			r = x[31:0];
		end else if (x[51]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/pqfd_mac.sv =====
// Shared multiply-accumulate unit: registered 33x33 product, then a 66-bit accumulator.
`timescale 1ns / 1ps
`default_nettype none
module pqfd_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pqfd_pkg::mac_ctl_t                 ctl,
	input  wire logic signed [pqfd_pkg::OPND_W-1:0] opa,
	input  wire logic signed [pqfd_pkg::OPND_W-1:0] opb,
	input  wire logic        [pqfd_pkg::ACC_W-1:0]  bias,
	output logic             [pqfd_pkg::ACC_W-1:0]  acc
);
	import pqfd_pkg::*;

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] prod_s1;
	logic        [ACC_W-1:0] bias_s1;
	logic                    vld_s1;
	logic                    first_s1;
	logic                    sub_s1;
	logic        [ACC_W-1:0] base;
	logic        [ACC_W-1:0] acc_q;

	// Multiply
	assign prod = opa * opb;

	// Register the product and its control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		bias_s1  <= bias;
		first_s1 <= ctl.first;
		sub_s1   <= ctl.sub;
	end

	// Start from the bias or add onto the running sum
	assign base = first_s1 ? bias_s1 : acc_q;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (sub_s1) begin
				acc_q <= base - prod_s1;
			end else begin
				acc_q <= base + prod_s1;
			end
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// ===== src/pqfd_seq.sv =====
// Step sequencer: walks the multiply schedule once per accepted sample.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pqfd_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            out_free,
	output logic                 busy,
	output pqfd_pkg::ctrl_t      ctrl
);
	import pqfd_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [STEP_W-1:0] step_q;
	logic              at_last;

	assign at_last = (step_q == LAST_STEP);
	assign busy    = (state_q == ST_RUN);

	// Decode the current step, quiet while idle
	always_comb begin
		ctrl = step_ctrl(step_q);
		if (state_q != ST_RUN) begin
			ctrl.mac     = '0;
			ctrl.cap_sel = CAP_NONE;
			ctrl.dif_p   = 1'b0;
			ctrl.dif_q   = 1'b0;
		end
		ctrl.fin = (state_q == ST_RUN) && at_last && out_free;
	end

	// Advance the step; hold on the last step until the output register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (!at_last) begin
						step_q <= step_q + 1'b1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
						step_q  <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_idle_step, (state_q == ST_IDLE) |-> (step_q == '0), "step moved while idle")
	`ASSERT_CLK(a_run_hold, ((state_q == ST_RUN) && !at_last) |=> (state_q == ST_RUN), "run ended before last step")
	`ASSERT_CLK(a_last_wait, ((state_q == ST_RUN) && at_last && !out_free) |=> ((state_q == ST_RUN) && $stable(step_q)), "last step not held while output full")

endmodule
`default_nettype wire

// ===== src/pq_filter_droop_controller.sv =====
// Top level: P-f / Q-V droop controller with first-order power filters.
//
//  channel   | signals                                   | beat
//  ----------+-------------------------------------------+----------------------------------
//  sample in | s_axis_tvalid/tready/tdata[63:0]          | v_alpha, v_beta, i_alpha, i_beta
//  result out| m_axis_tvalid/tready/tdata[127:0]         | p_f, q_f, v_ref, w_ref
//  config    | cfg_valid/cfg_ready/cfg_index/cfg_data    | register index, write data
//
// Each sample goes from the input beat through the 16 steps of the sequencer to the output beat;
// the step count is set by the single shared 33x33 multiplier doing 12 products.
// The next sample is taken the cycle after the result loads the output register.
// If the output register is still full at the last step, the sequencer holds there.
// arst_n clears the configuration, the filter history and all handshake state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pq_filter_droop_controller (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [63:0]   s_axis_tdata,   // volt_alpha, volt_beta, curr_alpha, curr_beta
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [127:0]       m_axis_tdata,   // filtered_active, filtered_reactive,
	                                           // volt_reference, freq_reference
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [pqfd_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [31:0]   cfg_data
);
	import pqfd_pkg::*;

	// Configuration
	logic [PWR_W-1:0]  freq_gain_q;
	logic [PWR_W-1:0]  volt_gain_q;
	logic [PWR_W-1:0]  p_set_q;
	logic [PWR_W-1:0]  q_set_q;
	logic [NOMF_W-1:0] nom_freq_q;
	logic [SMP_W-1:0]  coef_cur_q;
	logic [SMP_W-1:0]  coef_prev_q;
	logic [SMP_W-1:0]  coef_fb_q;

	// Sample and working values
	logic [SMP_W-1:0]  va_q, vb_q, ia_q, ib_q;
	logic [PWR_W-1:0]  p_q, q_q, pf_q, qf_q, wref_q;
	logic [OPND_W-1:0] dp_q, dq_q;

	// Filter history
	logic [PWR_W-1:0]  last_raw_p_q, last_filt_p_q, last_raw_q_q, last_filt_q_q;

	// Output register
	logic              m_vld_q;
	logic [PWR_W-1:0]  out_pf_q, out_qf_q, out_vref_q, out_wref_q;

	logic              accept;
	logic              busy;
	logic              out_free;
	ctrl_t             ctrl;
	logic [OPND_W-1:0] opa, opb;
	logic [ACC_W-1:0]  bias;
	logic [ACC_W-1:0]  acc;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_vld_q || m_axis_tready;
	assign s_axis_tready = !busy;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_gain_q <= '0;
			volt_gain_q <= '0;
			p_set_q     <= '0;
			q_set_q     <= '0;
			nom_freq_q  <= '0;
			coef_cur_q  <= '0;
			coef_prev_q <= '0;
			coef_fb_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FREQ_GAIN: freq_gain_q <= cfg_data;
				REG_VOLT_GAIN: volt_gain_q <= cfg_data;
				REG_P_SET:     p_set_q     <= cfg_data;
				REG_Q_SET:     q_set_q     <= cfg_data;
				REG_NOM_FREQ:  nom_freq_q  <= cfg_data[NOMF_W-1:0];
				REG_COEF_CUR:  coef_cur_q  <= cfg_data[SMP_W-1:0];
				REG_COEF_PREV: coef_prev_q <= cfg_data[SMP_W-1:0];
				REG_COEF_FB:   coef_fb_q   <= cfg_data[SMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Latch the sample beat
	always_ff @(posedge clk) begin
		if (accept) begin
			va_q <= s_axis_tdata[15:0];
			vb_q <= s_axis_tdata[31:16];
			ia_q <= s_axis_tdata[47:32];
			ib_q <= s_axis_tdata[63:48];
		end
	end

	pqfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	// Select multiplier operands
	always_comb begin
		unique case (ctrl.a_sel)
			A_VA:    opa = {{(OPND_W-SMP_W){va_q[SMP_W-1]}}, va_q};
			A_VB:    opa = {{(OPND_W-SMP_W){vb_q[SMP_W-1]}}, vb_q};
			A_CC:    opa = {{(OPND_W-SMP_W){coef_cur_q[SMP_W-1]}}, coef_cur_q};
			A_CP:    opa = {{(OPND_W-SMP_W){coef_prev_q[SMP_W-1]}}, coef_prev_q};
			A_CF:    opa = {{(OPND_W-SMP_W){coef_fb_q[SMP_W-1]}}, coef_fb_q};
			A_FG:    opa = {freq_gain_q[PWR_W-1], freq_gain_q};
			A_VG:    opa = {volt_gain_q[PWR_W-1], volt_gain_q};
			default: opa = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.b_sel)
			B_IA:    opb = {{(OPND_W-SMP_W){ia_q[SMP_W-1]}}, ia_q};
			B_IB:    opb = {{(OPND_W-SMP_W){ib_q[SMP_W-1]}}, ib_q};
			B_P:     opb = {p_q[PWR_W-1], p_q};
			B_LRP:   opb = {last_raw_p_q[PWR_W-1], last_raw_p_q};
			B_LFP:   opb = {last_filt_p_q[PWR_W-1], last_filt_p_q};
			B_Q:     opb = {q_q[PWR_W-1], q_q};
			B_LRQ:   opb = {last_raw_q_q[PWR_W-1], last_raw_q_q};
			B_LFQ:   opb = {last_filt_q_q[PWR_W-1], last_filt_q_q};
			B_DP:    opb = dp_q;
			B_DQ:    opb = dq_q;
			default: opb = '0;
		endcase
	end

	// Rounding constants; the nominal frequency rides in above the droop fraction
	always_comb begin
		unique case (ctrl.bias_sel)
			BIAS_ZERO: bias = '0;
			BIAS_FILT: bias = {{(ACC_W-14){1'b0}}, 14'h2000};
			BIAS_FREQ: bias = {{(ACC_W-NOMF_W-24){1'b0}}, nom_freq_q, 24'h80_0000};
			BIAS_VOLT: bias = {{(ACC_W-24){1'b0}}, 24'h80_0000};
			default:   bias = '0;
		endcase
	end

	pqfd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctrl.mac),
		.opa    (opa),
		.opb    (opb),
		.bias   (bias),
		.acc    (acc)
	);

	// Capture finished sums: halve the powers, scale and clamp the rest
	always_ff @(posedge clk) begin
		unique case (ctrl.cap_sel)
			CAP_P:    p_q    <= acc[PWR_W:1];
			CAP_Q:    q_q    <= acc[PWR_W:1];
			CAP_PF:   pf_q   <= sat32(acc[ACC_W-1:14]);
			CAP_QF:   qf_q   <= sat32(acc[ACC_W-1:14]);
			CAP_WREF: wref_q <= sat32({{10{acc[ACC_W-1]}}, acc[ACC_W-1:24]});
			default: begin
			end
		endcase
	end

	// Form the droop errors
	always_ff @(posedge clk) begin
		if (ctrl.dif_p) begin
			dp_q <= {p_set_q[PWR_W-1], p_set_q} - {pf_q[PWR_W-1], pf_q};
		end
		if (ctrl.dif_q) begin
			dq_q <= {q_set_q[PWR_W-1], q_set_q} - {qf_q[PWR_W-1], qf_q};
		end
	end

	// Advance the filter history when the result loads the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_p_q  <= '0;
			last_filt_p_q <= '0;
			last_raw_q_q  <= '0;
			last_filt_q_q <= '0;
		end else if (ctrl.fin) begin
			last_raw_p_q  <= p_q;
			last_filt_p_q <= pf_q;
			last_raw_q_q  <= q_q;
			last_filt_q_q <= qf_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (ctrl.fin) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	// Take the voltage reference straight from the finished sum on the last step
	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			out_pf_q   <= pf_q;
			out_qf_q   <= qf_q;
			out_vref_q <= sat32({{10{acc[ACC_W-1]}}, acc[ACC_W-1:24]});
			out_wref_q <= wref_q;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {out_wref_q, out_vref_q, out_qf_q, out_pf_q};

	`ASSERT_CLK(a_accept_busy, accept |=> !s_axis_tready, "sample taken while busy")
	`ASSERT_CLK(a_out_vld, (m_vld_q && !m_axis_tready) |=> m_vld_q, "result beat dropped")
	`ASSERT_CLK(a_out_hold, (m_vld_q && !m_axis_tready) |=> $stable(m_axis_tdata), "beat moved")

endmodule
`default_nettype wire

// ===== sim/tb_pq_filter_droop_controller.sv =====
// Testbench for the droop controller: directed table, then random phases against a predictor.
`timescale 1ns / 1ps
module tb_pq_filter_droop_controller;

	localparam int RAND_ITEMS     = 450;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int SHOW_LIMIT     = 10;

	// One sample beat, first field in the low bits of tdata
	typedef struct packed {
		logic signed [15:0] ib;
		logic signed [15:0] ia;
		logic signed [15:0] vb;
		logic signed [15:0] va;
	} sample_t;

	// One result beat, first field in the low bits of tdata
	typedef struct packed {
		logic signed [31:0] wref;
		logic signed [31:0] vref;
		logic signed [31:0] qf;
		logic signed [31:0] pf;
	} droop_out_t;

	// Directed table row: a register write or a sample, optionally with a known result
	typedef struct packed {
		logic                            is_cfg;
		logic [pqfd_pkg::CIDX_W-1:0]     idx;
		logic [31:0]                     val;
		sample_t                         smp;
		logic                            has_known;
		droop_out_t                      known;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [63:0]                   s_axis_tdata;   // volt_alpha, volt_beta, curr_alpha, curr_beta
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [127:0]                  m_axis_tdata;   // filtered_active, filtered_reactive,
	                                               // volt_reference, freq_reference
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [pqfd_pkg::CIDX_W-1:0]   cfg_index;
	logic [31:0]                   cfg_data;

	pq_filter_droop_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predictor copy of the registers and filter history
	logic signed [31:0] fgain, vgain, pset, qset;
	logic        [30:0] nomf;
	logic signed [15:0] c_cur, c_prev, c_fb;
	logic signed [31:0] raw_p_d, filt_p_d, raw_q_d, filt_q_d;

	droop_out_t  droop_expect_q[$];
	plan_row_t   dir_plan[$];

	int samples_in, results_out, reg_writes, setting_cnt;
	int errors, shown, idle_cnt, burst_left;
	int rx_mode, rx_span, rx_run;
	logic rx_lvl;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
		if (v > 80'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -80'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// First-order low-pass on one power channel, rounded half up at Q2.14
	function automatic logic signed [31:0] smooth(input logic signed [31:0] x,
			input logic signed [31:0] xp, input logic signed [31:0] fp);
		logic signed [79:0] acc;
		acc = c_cur * x + c_prev * xp - c_fb * fp;
		acc = (acc + 80'sd8192) >>> 14;
		return clamp32(acc);
	endfunction

	// Q8.24 gain times setpoint error, rounded half up
	function automatic logic signed [79:0] droop(input logic signed [31:0] gain,
			input logic signed [31:0] setp, input logic signed [31:0] meas);
		logic signed [79:0] acc;
		acc = gain * (setp - meas);
		return (acc + 80'sd8388608) >>> 24;
	endfunction

	// Compute the result of one sample and advance the filter history
	task automatic predict_droop(input sample_t s, output droop_out_t r);
		logic signed [79:0] sp, sq;
		logic signed [31:0] p, q;
		sp = $signed(s.va) * $signed(s.ia) + $signed(s.vb) * $signed(s.ib);
		sq = $signed(s.vb) * $signed(s.ia) - $signed(s.va) * $signed(s.ib);
		sp = sp >>> 1;
		sq = sq >>> 1;
		p = sp[31:0];
		q = sq[31:0];
		r.pf = smooth(p, raw_p_d, filt_p_d);
		r.qf = smooth(q, raw_q_d, filt_q_d);
		raw_p_d  = p;
		filt_p_d = r.pf;
		raw_q_d  = q;
		filt_q_d = r.qf;
		r.vref = clamp32(droop(vgain, qset, r.qf));
		r.wref = clamp32(droop(fgain, pset, r.pf) + $signed({1'b0, nomf}));
	endtask

	function automatic plan_row_t cfg_row(input logic [pqfd_pkg::CIDX_W-1:0] idx,
			input logic [31:0] val);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic plan_row_t smp_row(input int va, input int vb, input int ia, input int ib);
		plan_row_t r;
		r = '0;
		r.smp.va = va[15:0];
		r.smp.vb = vb[15:0];
		r.smp.ia = ia[15:0];
		r.smp.ib = ib[15:0];
		return r;
	endfunction

	function automatic plan_row_t known_row(input int va, input int vb, input int ia, input int ib,
			input int pf, input int qf, input int vref, input int wref);
		plan_row_t r;
		r = smp_row(va, vb, ia, ib);
		r.has_known = 1'b1;
		r.known.pf = pf;
		r.known.qf = qf;
		r.known.vref = vref;
		r.known.wref = wref;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_field();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// Random register value: extremes, zero, a unit gain, or anything in range
	function automatic logic [31:0] pick_reg(input logic [pqfd_pkg::CIDX_W-1:0] idx);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'h0;
			3: v = 32'h0100_0000;
			default: v = $urandom;
		endcase
		if (idx == pqfd_pkg::REG_NOM_FREQ)
			v[31] = 1'b0;
		else if (idx >= pqfd_pkg::REG_COEF_CUR)
			v = {{16{v[15]}}, v[15:0]};
		return v;
	endfunction

	// Write one register and mirror it into the predictor
	task automatic write_reg(input logic [pqfd_pkg::CIDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pqfd_pkg::REG_FREQ_GAIN: fgain  = val;
			pqfd_pkg::REG_VOLT_GAIN: vgain  = val;
			pqfd_pkg::REG_P_SET:     pset   = val;
			pqfd_pkg::REG_Q_SET:     qset   = val;
			pqfd_pkg::REG_NOM_FREQ:  nomf   = val[30:0];
			pqfd_pkg::REG_COEF_CUR:  c_cur  = val[15:0];
			pqfd_pkg::REG_COEF_PREV: c_prev = val[15:0];
			pqfd_pkg::REG_COEF_FB:   c_fb   = val[15:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold off between bursts, then open a new burst
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			repeat (gap) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				s_axis_tdata  = {$urandom, $urandom};
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	task automatic send_sample(input sample_t s, input logic has_known, input droop_out_t known);
		droop_out_t r;
		pace_sender();
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = s;
		do @(posedge clk); while (!s_axis_tready);
		predict_droop(s, r);
		droop_expect_q.push_back(has_known ? known : r);
		samples_in++;
	endtask

	// Drop valid and wait until every result is back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left = 0;
		while (droop_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] exp_v,
			input logic signed [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			if (shown < SHOW_LIMIT) begin
				shown++;
				$display("mismatch on result %0d, %s: expected %0d, got %0d",
					results_out, name, exp_v, act_v);
			end
		end
	endtask

	// Receiver: ready pattern that changes mode after each random span
	initial begin
		m_axis_tready = 1'b0;
		rx_lvl = 1'b0;
		rx_run = 0;
		forever begin
			rx_mode = $urandom_range(0, 2);
			rx_span = $urandom_range(64, 256);
			repeat (rx_span) begin
				@(negedge clk);
				case (rx_mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = $urandom_range(0, 1);
					default: begin
						if (rx_run == 0) begin
							rx_lvl = !rx_lvl;
							rx_run = rx_lvl ? $urandom_range(1, 8) : $urandom_range(1, 30);
						end
						rx_run--;
						m_axis_tready = rx_lvl;
					end
				endcase
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		droop_out_t exp_r, act_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			act_r = m_axis_tdata;
			if (droop_expect_q.size() == 0) begin
				errors++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("result beat %0d with nothing expected: %h", results_out, act_r);
				end
			end else begin
				exp_r = droop_expect_q.pop_front();
				check_field("filtered_active", exp_r.pf, act_r.pf);
				check_field("filtered_reactive", exp_r.qf, act_r.qf);
				check_field("volt_reference", exp_r.vref, act_r.vref);
				check_field("freq_reference", exp_r.wref, act_r.wref);
			end
			results_out++;
		end
	end

	// End the run if no beat moves on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cnt, droop_expect_q.size());
			$display("tb_pq_filter_droop_controller: done, errors");
			$finish;
		end
	end

	initial begin
		int n_rand, phase_len, lp_a;
		logic stable;
		logic [31:0] val;
		logic [pqfd_pkg::CIDX_W-1:0] idx;
		sample_t s;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		{fgain, vgain, pset, qset, nomf, c_cur, c_prev, c_fb} = '0;
		{raw_p_d, filt_p_d, raw_q_d, filt_q_d} = '0;
		samples_in = 0;
		results_out = 0;
		reg_writes = 0;
		setting_cnt = 1;
		errors = 0;
		shown = 0;
		idle_cnt = 0;
		burst_left = 0;

		dir_plan = '{
			// all registers zero after reset: every output is zero
			known_row(-32768, -32768, -32768, -32768, 0, 0, 0, 0),
			known_row(32767, 32767, 32767, 32767, 0, 0, 0, 0),
			known_row(-32768, 32767, 32767, -32768, 0, 0, 0, 0),
			// pass-through filter, unit gains: references are minus the powers
			cfg_row(pqfd_pkg::REG_COEF_CUR, 32'd16384),
			cfg_row(pqfd_pkg::REG_FREQ_GAIN, 32'h0100_0000),
			cfg_row(pqfd_pkg::REG_VOLT_GAIN, 32'h0100_0000),
			known_row(-32768, -32768, -32768, -32768, 1073741824, 0, 0, -1073741824),
			known_row(32767, 32767, 32767, 32767, 1073676289, 0, 0, -1073676289),
			// halving floors odd negative sums
			smp_row(1, 0, -1, 0),
			smp_row(0, -1, 1, 0),
			smp_row(-32768, 32767, 32767, -32768),
			// smallest coefficient: filter ties round up
			cfg_row(pqfd_pkg::REG_COEF_CUR, 32'd1),
			smp_row(128, 0, 128, 0),
			smp_row(-128, 0, 128, 0),
			// most negative coefficients and extreme gains: filter and references saturate
			cfg_row(pqfd_pkg::REG_COEF_CUR, 32'hFFFF_8000),
			cfg_row(pqfd_pkg::REG_COEF_PREV, 32'hFFFF_8000),
			cfg_row(pqfd_pkg::REG_COEF_FB, 32'hFFFF_8000),
			cfg_row(pqfd_pkg::REG_FREQ_GAIN, 32'h7FFF_FFFF),
			cfg_row(pqfd_pkg::REG_VOLT_GAIN, 32'h8000_0000),
			cfg_row(pqfd_pkg::REG_P_SET, 32'h8000_0000),
			cfg_row(pqfd_pkg::REG_Q_SET, 32'h7FFF_FFFF),
			cfg_row(pqfd_pkg::REG_NOM_FREQ, 32'h7FFF_FFFF),
			smp_row(32767, 32767, 32767, 32767),
			smp_row(32767, -32768, 32767, 32767),
			smp_row(-32768, -32768, -32768, -32768),
			smp_row(-32768, 32767, -32768, 32767),
			smp_row(0, 0, 0, 0),
			// largest positive coefficients, small gains, mid nominal
			cfg_row(pqfd_pkg::REG_COEF_CUR, 32'h0000_7FFF),
			cfg_row(pqfd_pkg::REG_COEF_PREV, 32'h0000_7FFF),
			cfg_row(pqfd_pkg::REG_COEF_FB, 32'h0000_7FFF),
			cfg_row(pqfd_pkg::REG_FREQ_GAIN, 32'hFFFF_FF80),
			cfg_row(pqfd_pkg::REG_VOLT_GAIN, 32'h0000_0081),
			cfg_row(pqfd_pkg::REG_NOM_FREQ, 32'h0000_4E20),
			smp_row(32767, 0, 32767, 0),
			smp_row(0, 32767, 32767, 0),
			smp_row(-12345, 23456, 345, -4567)
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table; writes wait for the pipe to drain
		foreach (dir_plan[k]) begin
			if (dir_plan[k].is_cfg) begin
				if (k == 0 || !dir_plan[k-1].is_cfg) begin
					settle();
					setting_cnt++;
				end
				write_reg(dir_plan[k].idx, dir_plan[k].val);
			end else begin
				send_sample(dir_plan[k].smp, dir_plan[k].has_known, dir_plan[k].known);
			end
		end

		// Random phases: new register set, then a run of samples
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			settle();
			setting_cnt++;
			stable = $urandom_range(0, 1);
			lp_a = $urandom_range(16, 4096);
			for (int i = 0; i < 8; i++) begin
				idx = i[pqfd_pkg::CIDX_W-1:0];
				val = pick_reg(idx);
				if (stable && (idx == pqfd_pkg::REG_COEF_CUR || idx == pqfd_pkg::REG_COEF_PREV))
					val = lp_a;
				else if (stable && idx == pqfd_pkg::REG_COEF_FB)
					val = -(16384 - 2 * lp_a);
				write_reg(idx, val);
			end
			phase_len = $urandom_range(20, 60);
			if (phase_len > RAND_ITEMS - n_rand)
				phase_len = RAND_ITEMS - n_rand;
			repeat (phase_len) begin
				s.va = rand_field();
				s.vb = rand_field();
				s.ia = rand_field();
				s.ib = rand_field();
				send_sample(s, 1'b0, '0);
				n_rand++;
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples under %0d register settings (%0d register writes)",
			samples_in, setting_cnt, reg_writes);
		$display("checked %0d result beats, %0d mismatches", results_out, errors);
		if (errors == 0)
			$display("tb_pq_filter_droop_controller: done, clean");
		else
			$display("tb_pq_filter_droop_controller: done, errors");
		$finish;
	end

endmodule
